// ===== hdl/wss_pkg.sv =====
// Shared constants and types for the wildcard substring search block.
package wss_pkg;

    localparam int PAT_REG_BYTES = 16;
    localparam int LEN_W         = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int TEXT_W        = 8;
    localparam int POS_W         = 16;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 24;

    localparam int              DEF_MAX_PATTERN = 16;
    localparam longint unsigned DEF_MAX_SUBJECT = 64'd65535;

    localparam logic [7:0] WILDCARD = 8'h2A;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

    typedef struct packed {
        logic [PAT_REG_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]              len;
    } pattern_t;

endpackage

// ===== hdl/wss_cfg.sv =====
// Pattern registers and effective pattern length.
module wss_cfg #(
    parameter int PAT = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [wss_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [wss_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output wss_pkg::pattern_t              pattern
);
    import wss_pkg::*;

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]      pat_len_reg;
    logic [LEN_W-1:0]      eff_len_reg;
    logic [LEN_W-1:0]      eff_len_next;
    logic [LEN_W-1:0]      lim;
    logic [PAT_REG_BYTES-1:0][7:0] bytes;

    assign bytes = {pat_high_reg, pat_low_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            eff_len_reg  <= '0;
        end else begin
            eff_len_reg <= eff_len_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_PAT_LOW:  pat_low_reg  <= cfg_wdata;
                    REG_PAT_HIGH: pat_high_reg <= cfg_wdata;
                    REG_PAT_LEN:  pat_len_reg  <= cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // The pattern ends at its first zero byte within the length in use.
    always_comb begin
        lim = (pat_len_reg > LEN_W'(PAT)) ? LEN_W'(PAT) : pat_len_reg;
        eff_len_next = lim;
        for (int i = PAT_REG_BYTES - 1; i >= 0; i--) begin
            if ((LEN_W'(i) < lim) && (bytes[i] == 8'd0)) begin
                eff_len_next = LEN_W'(i);
            end
        end
    end

    assign pattern.bytes = bytes;
    assign pattern.len   = eff_len_reg;

endmodule

// ===== hdl/wss_matcher.sv =====
// Parallel compare of the byte window that ends at the current byte with the pattern.
module wss_matcher #(
    parameter int PAT    = 16,
    parameter int HIST_D = 15,
    parameter int CNT_W  = 16
) (
    input  logic [wss_pkg::TEXT_W-1:0] text_byte,
    input  logic [HIST_D-1:0][7:0]     hist,
    input  logic [CNT_W-1:0]           count,
    input  wss_pkg::pattern_t          pattern,
    output logic                       hit
);
    import wss_pkg::*;

    localparam int KW    = (PAT > 1) ? $clog2(PAT) : 1;
    localparam int WIN   = 1 << KW;
    localparam int CMP_W = CNT_W + LEN_W + 1;

    logic [7:0]    win [WIN];
    logic [KW-1:0] idx;
    logic [7:0]    pb;
    logic          long_enough;

    always_comb begin
        for (int k = 0; k < WIN; k++) begin
            if (k == 0) begin
                win[k] = text_byte;
            end else if (k < PAT) begin
                win[k] = hist[k-1];
            end else begin
                win[k] = 8'd0;
            end
        end
    end

    assign long_enough = (CMP_W'(count) + CMP_W'(1)) >= CMP_W'(pattern.len);

    always_comb begin
        hit = long_enough && (pattern.len != '0);
        idx = '0;
        pb  = '0;
        for (int i = 0; i < PAT; i++) begin
            if (LEN_W'(i) < pattern.len) begin
                idx = KW'(pattern.len - LEN_W'(i) - LEN_W'(1));
                pb  = pattern.bytes[i];
                if ((pb != WILDCARD) && (pb != win[idx])) begin
                    hit = 1'b0;
                end
            end
        end
    end

endmodule

// ===== hdl/wildcard_substring_search.sv =====
// Top level of the streaming wildcard substring search.
//
// The subject text enters one byte per transfer on the s_ channel; a zero
// byte ends the subject. Each subject gives exactly one result transfer on
// the m_ channel: found with the offset just past the leftmost match, or
// not-found with offset zero when the end byte comes first or the subject
// grows past MAX_SUBJECT bytes. Bytes after a reported match are dropped
// up to the end byte. The pattern (up to 16 bytes, 0x2A matches any byte)
// is to be loaded through the write port while the block is idle; the
// block does not enforce this. A byte is taken into an input register,
// compared there with the history window, and the result is registered
// to drive m_tvalid. One byte is taken every cycle unless a result waits
// on a low m_tready; the combinational window compare and the result
// register set that rate. If m_tready is low with a result waiting, the
// input register can still take a byte while empty, then s_tready drops
// until the result is taken. Reset clears the pattern, the history, the
// position count and any waiting result; s_tready is high out of reset.
module wildcard_substring_search #(
    parameter int              MAX_PATTERN = wss_pkg::DEF_MAX_PATTERN,
    parameter longint unsigned MAX_SUBJECT = wss_pkg::DEF_MAX_SUBJECT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [wss_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [wss_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wss_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] text_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [wss_pkg::M_TDATA_W-1:0]  m_tdata    // [0] found, [16:1] end_position
);
    import wss_pkg::*;

    localparam int PAT    = (MAX_PATTERN < PAT_REG_BYTES) ? MAX_PATTERN : PAT_REG_BYTES;
    localparam int HIST_D = (PAT > 1) ? PAT - 1 : 1;
    localparam int CNT_W  = $clog2(MAX_SUBJECT + 64'd1);

    pattern_t pattern;

    logic              in_valid_reg;
    logic [TEXT_W-1:0] in_byte_reg;
    logic [HIST_D-1:0][7:0] hist_reg, hist_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rep_reg, rep_next;
    logic              out_valid_reg;
    logic              out_found_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              emit;
    logic              res_found;
    logic [POS_W-1:0]  res_pos;
    logic              advance;
    logic              proc;
    logic              hit;

    wss_cfg #(.PAT(PAT)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pattern   (pattern)
    );

    wss_matcher #(.PAT(PAT), .HIST_D(HIST_D), .CNT_W(CNT_W)) u_matcher (
        .text_byte (in_byte_reg),
        .hist      (hist_reg),
        .count     (cnt_reg),
        .pattern   (pattern),
        .hit       (hit)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = advance || !in_valid_reg;

    always_comb begin
        hist_next = hist_reg;
        cnt_next  = cnt_reg;
        rep_next  = rep_reg;
        emit      = 1'b0;
        res_found = 1'b0;
        res_pos   = '0;
        if (in_byte_reg == '0) begin
            hist_next = '0;
            cnt_next  = '0;
            rep_next  = 1'b0;
            emit      = !rep_reg;
        end else if (rep_reg) begin
            emit = 1'b0;
        end else if (cnt_reg == CNT_W'(MAX_SUBJECT)) begin
            rep_next = 1'b1;
            emit     = 1'b1;
        end else if (pattern.len == '0) begin
            rep_next  = 1'b1;
            emit      = 1'b1;
            res_found = 1'b1;
            res_pos   = POS_W'(cnt_reg);
        end else begin
            for (int k = HIST_D - 1; k > 0; k--) begin
                hist_next[k] = hist_reg[k-1];
            end
            hist_next[0] = in_byte_reg;
            cnt_next     = cnt_reg + CNT_W'(1);
            if (hit) begin
                rep_next  = 1'b1;
                emit      = 1'b1;
                res_found = 1'b1;
                res_pos   = POS_W'(cnt_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            hist_reg      <= '0;
            cnt_reg       <= '0;
            rep_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (proc) begin
                hist_reg <= hist_next;
                cnt_reg  <= cnt_next;
                rep_reg  <= rep_next;
            end
            if (proc && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata[TEXT_W-1:0];
        end
        if (proc && emit) begin
            out_found_reg <= res_found;
            out_pos_reg   <= res_pos;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - POS_W - 1){1'b0}}, out_pos_reg, out_found_reg};

    // A not-found result always carries offset zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] || (m_tdata[16:1] == 16'd0)))
        else $error("not-found result with nonzero offset");

    // The position count never passes the subject limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (64'(cnt_reg) <= 64'(MAX_SUBJECT)))
        else $error("position count beyond subject limit");

    // An end byte returns the subject state to its start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && (in_byte_reg == '0)) |=> ((cnt_reg == '0) && !rep_reg))
        else $error("subject state not cleared at end byte");

    // A found result marks the subject as reported.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && emit && res_found) |=> rep_reg)
        else $error("match reported without setting report flag");

endmodule
